FILE: rtl/segq_pkg.sv
// shared types and constants for the segment versus quad hit test
package segq_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int NUM_SIDES = 4;
  localparam int NUM_CORNERS = 4;
  localparam int ORIENT_STAGES = 3;

  // corner pairs that make up each side: 0-1, 1-2, 2-3, 0-3
  localparam int SIDE_FIRST [NUM_SIDES] = '{0, 1, 2, 0};
  localparam int SIDE_SECOND [NUM_SIDES] = '{1, 2, 3, 3};

  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

  typedef struct packed {
    orient_t o_start;
    orient_t o_end;
    orient_t o_first;
    orient_t o_second;
    logic w_start;
    logic w_end;
    logic w_first;
    logic w_second;
  } side_test_t;

endpackage

FILE: rtl/segq_orient.sv
// three stage orientation unit: sign of (q - p) x (r - p)
module segq_orient #(
  parameter int COORD_WIDTH = segq_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  input  logic signed [COORD_WIDTH-1:0] r_x,
  input  logic signed [COORD_WIDTH-1:0] r_y,
  output segq_pkg::orient_t             sign
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] ux;
  logic signed [DW-1:0] uy;
  logic signed [DW-1:0] vx;
  logic signed [DW-1:0] vy;
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [SW-1:0] cross_prod;

  assign cross_prod = SW'(prod_a) - SW'(prod_b);

  always_ff @(posedge clk) begin
    ux <= DW'(q_x) - DW'(p_x);
    uy <= DW'(q_y) - DW'(p_y);
    vx <= DW'(r_x) - DW'(p_x);
    vy <= DW'(r_y) - DW'(p_y);
    prod_a <= PW'(ux) * PW'(vy);
    prod_b <= PW'(uy) * PW'(vx);
    sign.neg <= cross_prod[SW-1];
    sign.zero <= (cross_prod == '0);
  end

endmodule

FILE: rtl/segq_bounds.sv
// bounding box test of r against segment p-q, delayed to match the orientation units
module segq_bounds #(
  parameter int COORD_WIDTH = segq_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] p_x,
  input  logic signed [COORD_WIDTH-1:0] p_y,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  input  logic signed [COORD_WIDTH-1:0] r_x,
  input  logic signed [COORD_WIDTH-1:0] r_y,
  output logic                          in_box
);

  logic                                 box_now;
  logic [segq_pkg::ORIENT_STAGES-1:0]   pipe;

  assign box_now = (r_x >= p_x || r_x >= q_x) && (r_x <= p_x || r_x <= q_x) &&
                   (r_y >= p_y || r_y >= q_y) && (r_y <= p_y || r_y <= q_y);

  always_ff @(posedge clk) begin
    pipe <= {pipe[segq_pkg::ORIENT_STAGES-2:0], box_now};
  end

  assign in_box = pipe[segq_pkg::ORIENT_STAGES-1];

endmodule

FILE: rtl/segq_decide.sv
// per side hit decision and result register
module segq_decide (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        valid,
  input  segq_pkg::side_test_t [segq_pkg::NUM_SIDES-1:0] tests,
  output logic                                        done,
  output logic                                        hit,
  output logic [segq_pkg::NUM_SIDES-1:0]              side_mask
);

  logic [segq_pkg::NUM_SIDES-1:0] mask_now;

  always_comb begin
    for (int s = 0; s < segq_pkg::NUM_SIDES; s++) begin
      mask_now[s] =
        (!tests[s].o_start.zero && !tests[s].o_end.zero &&
         (tests[s].o_start.neg != tests[s].o_end.neg) &&
         !tests[s].o_first.zero && !tests[s].o_second.zero &&
         (tests[s].o_first.neg != tests[s].o_second.neg)) ||
        (tests[s].o_start.zero && tests[s].w_start) ||
        (tests[s].o_end.zero && tests[s].w_end) ||
        (tests[s].o_first.zero && tests[s].w_first) ||
        (tests[s].o_second.zero && tests[s].w_second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
    hit <= |mask_now;
    side_mask <= mask_now;
  end

endmodule

FILE: rtl/segment_quad_hit_test_core.sv
// top level of the segment versus quad hit test pipeline
//
// channel  | handshake      | ports
// ---------+----------------+------------------------------------------------
// request  | start & !busy  | ray_start_x/y, ray_end_x/y, corner0..3_x/y
// result   | done (1 cycle) | hit, side_mask
//
// one request per cycle while busy is low
// stages: differences and box compares, products, cross sign, side decision
// the product stage of the orientation units sets the clock limit
// busy is high only during reset; rst clears the valid chain
// results cannot be held off, so the pipeline never stalls
module segment_quad_hit_test_core #(
  parameter int COORD_WIDTH = segq_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  ray_start_x,
  input  logic signed [COORD_WIDTH-1:0]  ray_start_y,
  input  logic signed [COORD_WIDTH-1:0]  ray_end_x,
  input  logic signed [COORD_WIDTH-1:0]  ray_end_y,
  input  logic signed [COORD_WIDTH-1:0]  corner0_x,
  input  logic signed [COORD_WIDTH-1:0]  corner0_y,
  input  logic signed [COORD_WIDTH-1:0]  corner1_x,
  input  logic signed [COORD_WIDTH-1:0]  corner1_y,
  input  logic signed [COORD_WIDTH-1:0]  corner2_x,
  input  logic signed [COORD_WIDTH-1:0]  corner2_y,
  input  logic signed [COORD_WIDTH-1:0]  corner3_x,
  input  logic signed [COORD_WIDTH-1:0]  corner3_y,
  output logic                           done,
  output logic                           hit,
  output logic [segq_pkg::NUM_SIDES-1:0] side_mask
);

  logic signed [COORD_WIDTH-1:0]              kx [segq_pkg::NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0]              ky [segq_pkg::NUM_CORNERS];
  segq_pkg::orient_t                          ray_orient [segq_pkg::NUM_CORNERS];
  logic                                       ray_box [segq_pkg::NUM_CORNERS];
  segq_pkg::side_test_t [segq_pkg::NUM_SIDES-1:0] tests;
  logic [segq_pkg::ORIENT_STAGES-1:0]         valid_pipe;
  logic                                       accept;

  assign busy = rst;
  assign accept = start && !busy;

  assign kx[0] = corner0_x;
  assign ky[0] = corner0_y;
  assign kx[1] = corner1_x;
  assign ky[1] = corner1_y;
  assign kx[2] = corner2_x;
  assign ky[2] = corner2_y;
  assign kx[3] = corner3_x;
  assign ky[3] = corner3_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[segq_pkg::ORIENT_STAGES-2:0], accept};
    end
  end

  // corner side of the ray line and corner inside the ray box
  for (genvar c = 0; c < segq_pkg::NUM_CORNERS; c++) begin : g_corner
    segq_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient (
      .clk (clk),
      .p_x (ray_start_x), .p_y (ray_start_y),
      .q_x (ray_end_x),   .q_y (ray_end_y),
      .r_x (kx[c]),       .r_y (ky[c]),
      .sign(ray_orient[c])
    );
    segq_bounds #(.COORD_WIDTH(COORD_WIDTH)) u_bounds (
      .clk   (clk),
      .p_x   (ray_start_x), .p_y (ray_start_y),
      .q_x   (ray_end_x),   .q_y (ray_end_y),
      .r_x   (kx[c]),       .r_y (ky[c]),
      .in_box(ray_box[c])
    );
  end

  // ray end points against each side
  for (genvar s = 0; s < segq_pkg::NUM_SIDES; s++) begin : g_side
    localparam int F = segq_pkg::SIDE_FIRST[s];
    localparam int G = segq_pkg::SIDE_SECOND[s];

    segq_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_start (
      .clk (clk),
      .p_x (kx[F]), .p_y (ky[F]),
      .q_x (kx[G]), .q_y (ky[G]),
      .r_x (ray_start_x), .r_y (ray_start_y),
      .sign(tests[s].o_start)
    );
    segq_orient #(.COORD_WIDTH(COORD_WIDTH)) u_orient_end (
      .clk (clk),
      .p_x (kx[F]), .p_y (ky[F]),
      .q_x (kx[G]), .q_y (ky[G]),
      .r_x (ray_end_x), .r_y (ray_end_y),
      .sign(tests[s].o_end)
    );
    segq_bounds #(.COORD_WIDTH(COORD_WIDTH)) u_bounds_start (
      .clk   (clk),
      .p_x   (kx[F]), .p_y (ky[F]),
      .q_x   (kx[G]), .q_y (ky[G]),
      .r_x   (ray_start_x), .r_y (ray_start_y),
      .in_box(tests[s].w_start)
    );
    segq_bounds #(.COORD_WIDTH(COORD_WIDTH)) u_bounds_end (
      .clk   (clk),
      .p_x   (kx[F]), .p_y (ky[F]),
      .q_x   (kx[G]), .q_y (ky[G]),
      .r_x   (ray_end_x), .r_y (ray_end_y),
      .in_box(tests[s].w_end)
    );

    assign tests[s].o_first = ray_orient[F];
    assign tests[s].o_second = ray_orient[G];
    assign tests[s].w_first = ray_box[F];
    assign tests[s].w_second = ray_box[G];
  end

  segq_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .valid    (valid_pipe[segq_pkg::ORIENT_STAGES-1]),
    .tests    (tests),
    .done     (done),
    .hit      (hit),
    .side_mask(side_mask)
  );

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("request without result");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without request");

  a_hit_matches_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit == (side_mask != '0)))
    else $error("hit disagrees with side mask");

endmodule
